FILE: hw/rtl/gbn_pkg.sv
// Package for the go-back-N sender: payload types, codes and control structs.
`timescale 1ns / 1ps
package gbn_pkg;

  localparam int unsigned SeqWidth  = 16;
  localparam int unsigned MaxWindow = 32;
  localparam int unsigned ResultCap = 32;

  localparam int unsigned CmpWidth = (SeqWidth < 16) ? SeqWidth : 16;
  localparam logic [15:0] SeqMask  =
    (CmpWidth >= 16) ? 16'hFFFF : 16'((32'd1 << CmpWidth) - 32'd1);
  localparam int unsigned WinLimit = (MaxWindow < ResultCap) ? MaxWindow : ResultCap;

  localparam logic [15:0] TotalPacketsReset = 16'd1000;
  localparam logic [5:0]  WindowSizeReset   = 6'd8;
  localparam logic [15:0] TimeoutTicksReset = 16'd1500;

  localparam logic [1:0] EvStart = 2'd0;
  localparam logic [1:0] EvAck   = 2'd1;
  localparam logic [1:0] EvTick  = 2'd2;

  localparam logic [1:0] CfgTotalPackets = 2'd0;
  localparam logic [1:0] CfgWindowSize   = 2'd1;
  localparam logic [1:0] CfgTimeoutTicks = 2'd2;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] ack_number;
  } in_t;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] send_sequence;
    logic [31:0] retransmitted_total;
    logic        transfer_done;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic apply;
    logic emit_send;
    logic emit_idle;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic fill_now;
    logic fill_after;
  } status_t;

endpackage

FILE: hw/rtl/gbn_datapath.sv
// Datapath of the go-back-N sender: window state, timer, totals, config and output register.
`timescale 1ns / 1ps
module gbn_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbn_pkg::in_t     in_i,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output gbn_pkg::out_t    out_o,
  input  gbn_pkg::cmd_t    cmd_i,
  output gbn_pkg::status_t status_o
);

  logic [15:0] total_q, timeout_q;
  logic [5:0]  wsize_q;
  logic [15:0] base_q, base_d, next_q, next_d, count_q, count_d;
  logic [31:0] resend_q, resend_d;
  logic        active_q, active_d, done_q, done_d, fill_en_q, fill_en_d;
  logic [5:0]  n_q;
  logic        out_valid_q;
  gbn_pkg::out_t out_q;

  logic [5:0]  win;
  logic [15:0] diff, diff1, limit, cnt1;
  logic [16:0] base1;
  logic [32:0] sum;

  // effective window: zero acts as one, capped
  always_comb begin
    win = (wsize_q == 6'd0) ? 6'd1 : wsize_q;
    if (32'(win) > gbn_pkg::WinLimit) win = 6'(gbn_pkg::WinLimit);
  end

  assign diff  = next_q - base_q;
  assign diff1 = diff + 16'd1;
  assign base1 = {1'b0, base_q} + 17'd1;
  assign limit = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
  assign cnt1  = count_q + 16'd1;
  assign sum   = {1'b0, resend_q} + 33'(diff[5:0]);

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.fill_now = fill_en_q && active_q && (next_q < total_q) &&
                             (diff < 16'(win)) && (32'(n_q) < gbn_pkg::ResultCap);
  assign status_o.fill_after = fill_en_q && active_q &&
                               (({1'b0, next_q} + 17'd1) < {1'b0, total_q}) &&
                               (diff1 < 16'(win)) &&
                               ((32'(n_q) + 32'd1) < gbn_pkg::ResultCap);

  always_comb begin
    base_d    = base_q;
    next_d    = next_q;
    count_d   = count_q;
    resend_d  = resend_q;
    active_d  = active_q;
    done_d    = done_q;
    fill_en_d = 1'b0;
    case (in_i.event_kind)
      gbn_pkg::EvStart: begin
        base_d    = '0;
        next_d    = '0;
        count_d   = '0;
        resend_d  = '0;
        active_d  = (total_q != 16'd0);
        done_d    = (total_q == 16'd0);
        fill_en_d = 1'b1;
      end
      gbn_pkg::EvAck: begin
        if (active_q && (base_q < next_q) &&
            (in_i.ack_number == (base_q & gbn_pkg::SeqMask))) begin
          base_d    = base1[15:0];
          count_d   = '0;
          fill_en_d = 1'b1;
          if (base1 >= {1'b0, total_q}) begin
            active_d = 1'b0;
            done_d   = 1'b1;
          end
        end
      end
      gbn_pkg::EvTick: begin
        if (active_q) begin
          if (cnt1 >= limit) begin
            count_d   = '0;
            resend_d  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            next_d    = base_q;
            fill_en_d = 1'b1;
          end else begin
            count_d = cnt1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= gbn_pkg::TotalPacketsReset;
      wsize_q     <= gbn_pkg::WindowSizeReset;
      timeout_q   <= gbn_pkg::TimeoutTicksReset;
      base_q      <= '0;
      next_q      <= '0;
      count_q     <= '0;
      resend_q    <= '0;
      active_q    <= 1'b0;
      done_q      <= 1'b0;
      fill_en_q   <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          gbn_pkg::CfgTotalPackets: total_q   <= cfg_data_i;
          gbn_pkg::CfgWindowSize:   wsize_q   <= cfg_data_i[5:0];
          gbn_pkg::CfgTimeoutTicks: timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.apply) begin
        base_q    <= base_d;
        next_q    <= next_d;
        count_q   <= count_d;
        resend_q  <= resend_d;
        active_q  <= active_d;
        done_q    <= done_d;
        fill_en_q <= fill_en_d;
        n_q       <= '0;
      end else if (cmd_i.emit_send) begin
        next_q <= next_q + 16'd1;
        n_q    <= n_q + 6'd1;
      end
      if (cmd_i.emit_send || cmd_i.emit_idle) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_send) begin
      out_q.send_valid          <= 1'b1;
      out_q.send_sequence       <= next_q & gbn_pkg::SeqMask;
      out_q.retransmitted_total <= resend_q;
      out_q.transfer_done       <= done_q;
      out_q.last_of_run         <= !status_o.fill_after;
    end else if (cmd_i.emit_idle) begin
      out_q.send_valid          <= 1'b0;
      out_q.send_sequence       <= '0;
      out_q.retransmitted_total <= resend_q;
      out_q.transfer_done       <= done_q;
      out_q.last_of_run         <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hw/rtl/gbn_controller.sv
// Controller of the go-back-N sender: takes an event beat, then sequences result beats.
`timescale 1ns / 1ps
module gbn_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gbn_pkg::status_t status_i,
  output gbn_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.apply = 1'b1;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          if (status_i.fill_now) begin
            cmd_o.emit_send = 1'b1;
            if (!status_i.fill_after) state_d = StIdle;
          end else begin
            cmd_o.emit_idle = 1'b1;
            state_d         = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/go_back_n_sender_unit.sv
// Go-back-N sender: an event beat in, one or more result beats out.
// An event is taken while idle, then result beats follow one a cycle while the output
// is free; a timeout or start emits up to a window (32) of beats.
// A new event is not taken until the last result beat of the previous one is emitted.
// Reset (rst_ni low, async): idle, window state cleared, config registers at 1000/8/1500.
`timescale 1ns / 1ps
module go_back_n_sender_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gbn_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gbn_pkg::out_t out_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  gbn_pkg::cmd_t    cmd;
  gbn_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  gbn_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbn_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
